>>> design/mbz_pkg.sv
`default_nettype none

package mbz_pkg;

   // Grid size default and fixed-point format
   localparam int MAX_POINTS_DEF = 16;
   localparam int FRAC_W         = 16;
   localparam logic [FRAC_W:0] ONE_Q16 = 17'h1_0000;

   // Request function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Control register indexes
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_SPACING_X  = 3'd2,
      CSR_SPACING_Y  = 3'd3,
      CSR_POINTS_X   = 3'd4,
      CSR_POINTS_Y   = 3'd5,
      CSR_MESH_VALID = 3'd6
   } csr_idx_type;

   // Control register reset values
   localparam logic signed [31:0] ORIGIN_X_RST  = 32'sd0;
   localparam logic signed [31:0] ORIGIN_Y_RST  = 32'sd0;
   localparam logic [30:0]        SPACING_X_RST = 31'd1638400;
   localparam logic [30:0]        SPACING_Y_RST = 31'd1747627;
   localparam logic [4:0]         POINTS_X_RST  = 5'd6;
   localparam logic [4:0]         POINTS_Y_RST  = 5'd4;
   localparam logic               MESH_VALID_RST = 1'b0;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic [30:0]        spacing_x;
      logic [30:0]        spacing_y;
      logic [4:0]         points_x;
      logic [4:0]         points_y;
      logic               mesh_valid;
   } cfg_type;

   // Which interpolation the shared lerp unit is working on
   typedef enum logic [1:0] {
      LERP_LEFT  = 2'd0,
      LERP_RIGHT = 2'd1,
      LERP_FINAL = 2'd2
   } lerp_sel_type;

   typedef enum logic [1:0] {
      LSTEP_IDLE = 2'd0,
      LSTEP_DIFF = 2'd1,
      LSTEP_MUL  = 2'd2,
      LSTEP_ADD  = 2'd3
   } lerp_step_type;

   // Controller to datapath commands
   typedef struct packed {
      logic          mem_wr;
      logic          capture;
      logic          res_clr;
      logic          div_start;
      logic          locate;
      logic          rd_en;
      logic [1:0]    rd_sel;
      logic          cap_en;
      logic [1:0]    cap_sel;
      lerp_step_type lerp_step;
      lerp_sel_type  lerp_sel;
      logic          out_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_done;
   } sts_type;

endpackage

`default_nettype wire

>>> design/mbz_div.sv
`default_nettype none

module mbz_div #(
   parameter int IDX_W = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [30:0]                       rel,
   input  logic [30:0]                       divisor,
   output logic [IDX_W+mbz_pkg::FRAC_W-1:0]  quot,
   output logic                              done
);
   import mbz_pkg::*;

   localparam int QW    = IDX_W + FRAC_W;
   localparam int CNT_W = $clog2(QW + 1);

   logic [31:0]      rem_ff;
   logic [QW-1:0]    acc_ff;
   logic [30:0]      dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [31:0] shift_rem;
   logic        ge;

   // One restoring step: shift in the next dividend bit, subtract when it fits
   assign shift_rem = {rem_ff[30:0], acc_ff[QW-1]};
   assign ge        = shift_rem >= {1'b0, dvs_ff};

   // Upper dividend bits seed the remainder; the rest shift through acc_ff
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         rem_ff  <= 32'(rel >> IDX_W);
         acc_ff  <= {rel[IDX_W-1:0], FRAC_W'(0)};
         dvs_ff  <= divisor;
         cnt_ff  <= CNT_W'(QW);
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         rem_ff <= ge ? (shift_rem - {1'b0, dvs_ff}) : shift_rem;
         acc_ff <= {acc_ff[QW-2:0], ge};
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign quot = acc_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

>>> design/mbz_datapath.sv
`default_nettype none

module mbz_datapath #(
   parameter int MAX_POINTS = mbz_pkg::MAX_POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  mbz_pkg::cfg_type   cfg,
   input  mbz_pkg::cmd_type   cmd,
   output mbz_pkg::sts_type   sts,
   input  logic [3:0]         req_grid_col,
   input  logic [3:0]         req_grid_row,
   input  logic signed [31:0] req_entry_value,
   input  logic signed [31:0] req_query_x,
   input  logic signed [31:0] req_query_y,
   output logic signed [31:0] rsp_z_adj
);
   import mbz_pkg::*;

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int QW     = IDX_W + FRAC_W;
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int PW     = IDX_W + 31;

   function automatic logic [31:0] sat33(input logic [32:0] v);
      if (v[32] != v[31]) begin
         return v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] sat35(input logic [34:0] v);
      if (v[34:31] != {4{v[34]}}) begin
         return v[34] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      return v[31:0];
   endfunction

   // ---------------------------------------------------------------- grid store
   logic [31:0]       grid_mem [DEPTH];
   logic [31:0]       rd_data_ff;
   logic [IDX_W+3:0]  ld_col_w;
   logic [IDX_W+3:0]  ld_row_w;
   logic              ld_in_range;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   assign ld_col_w    = (IDX_W+4)'(req_grid_col);
   assign ld_row_w    = (IDX_W+4)'(req_grid_row);
   assign ld_in_range = (ld_col_w < (IDX_W+4)'(MAX_POINTS)) &&
                        (ld_row_w < (IDX_W+4)'(MAX_POINTS));
   assign wr_addr     = {ld_row_w[IDX_W-1:0], ld_col_w[IDX_W-1:0]};

   // Write on load, read one corner per cycle
   always_ff @(posedge clock) begin
      if (cmd.mem_wr && ld_in_range) begin
         grid_mem[wr_addr] <= req_entry_value;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------- axis setup
   // Index 0 is x, index 1 is y
   logic signed [31:0] origin_a [2];
   logic signed [31:0] qpos_a   [2];
   logic [30:0]        sp_eff   [2];
   logic [4:0]         pts_a    [2];
   logic [7:0]         pts8_a   [2];
   logic [IDX_W-1:0]   last_a   [2];
   logic [32:0]        dpos_a   [2];
   logic [31:0]        rel_in   [2];
   logic [31:0]        rel_ff   [2];
   logic [PW-1:0]      beyond_prod_ff [2];
   logic [QW-1:0]      quot_a   [2];
   logic [1:0]         div_done_a;
   logic [IDX_W-1:0]   lo_in    [2];
   logic [IDX_W-1:0]   hi_in    [2];
   logic [FRAC_W:0]    frac_in  [2];
   logic [IDX_W-1:0]   lo_ff    [2];
   logic [IDX_W-1:0]   hi_ff    [2];
   logic [FRAC_W:0]    frac_ff  [2];

   assign origin_a[0] = cfg.origin_x;
   assign origin_a[1] = cfg.origin_y;
   assign qpos_a[0]   = req_query_x;
   assign qpos_a[1]   = req_query_y;
   assign pts_a[0]    = cfg.points_x;
   assign pts_a[1]    = cfg.points_y;
   assign sp_eff[0]   = (cfg.spacing_x == '0) ? 31'd1 : cfg.spacing_x;
   assign sp_eff[1]   = (cfg.spacing_y == '0) ? 31'd1 : cfg.spacing_y;

   // Clamp the point count, relative position saturates to 32 bits
   always_comb begin
      for (int ax = 0; ax < 2; ax++) begin
         pts8_a[ax] = 8'(pts_a[ax]);
         if (pts8_a[ax] > 8'(MAX_POINTS)) begin
            last_a[ax] = IDX_W'(MAX_POINTS - 1);
         end else if (pts8_a[ax] == 8'd0) begin
            last_a[ax] = '0;
         end else begin
            last_a[ax] = IDX_W'(pts8_a[ax] - 8'd1);
         end
         dpos_a[ax] = {qpos_a[ax][31], qpos_a[ax]} - {origin_a[ax][31], origin_a[ax]};
         rel_in[ax] = sat33(dpos_a[ax]);
      end
   end

   // Near edge, far edge or interior cell with its Q1.16 fraction
   always_comb begin
      for (int ax = 0; ax < 2; ax++) begin
         priority if (rel_ff[ax][31]) begin
            lo_in[ax]   = '0;
            hi_in[ax]   = '0;
            frac_in[ax] = ONE_Q16;
         end else if (PW'(rel_ff[ax][30:0]) >= beyond_prod_ff[ax]) begin
            lo_in[ax]   = last_a[ax];
            hi_in[ax]   = last_a[ax];
            frac_in[ax] = ONE_Q16;
         end else begin
            lo_in[ax]   = quot_a[ax][QW-1:FRAC_W];
            hi_in[ax]   = quot_a[ax][QW-1:FRAC_W] + IDX_W'(1);
            frac_in[ax] = {1'b0, quot_a[ax][FRAC_W-1:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int ax = 0; ax < 2; ax++) begin
         if (cmd.capture) begin
            rel_ff[ax] <= rel_in[ax];
         end
         // Position of the last grid line, for the far-edge test
         if (cmd.div_start) begin
            beyond_prod_ff[ax] <= PW'(last_a[ax]) * PW'(sp_eff[ax]);
         end
         if (cmd.locate) begin
            lo_ff[ax]   <= lo_in[ax];
            hi_ff[ax]   <= hi_in[ax];
            frac_ff[ax] <= frac_in[ax];
         end
      end
   end

   // Quotient and fraction come out of one division of rel * 65536 by spacing
   for (genvar ax = 0; ax < 2; ax++) begin : g_div
      mbz_div #(
         .IDX_W (IDX_W)
      ) u_div (
         .clock   (clock),
         .reset   (reset),
         .start   (cmd.div_start),
         .rel     (rel_ff[ax][30:0]),
         .divisor (sp_eff[ax]),
         .quot    (quot_a[ax]),
         .done    (div_done_a[ax])
      );
   end

   assign sts.div_done = div_done_a[0] & div_done_a[1];

   // ---------------------------------------------------------------- corner read
   logic [IDX_W-1:0] rd_col;
   logic [IDX_W-1:0] rd_row;
   logic [31:0]      cell_ff [4];

   assign rd_col  = cmd.rd_sel[1] ? hi_ff[0] : lo_ff[0];
   assign rd_row  = cmd.rd_sel[0] ? hi_ff[1] : lo_ff[1];
   assign rd_addr = {rd_row, rd_col};

   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         cell_ff[cmd.cap_sel] <= rd_data_ff;
      end
   end

   // ---------------------------------------------------------------- lerp unit
   logic [31:0]     lerp_a;
   logic [31:0]     lerp_b;
   logic [FRAC_W:0] lerp_f;
   logic [32:0]     lerp_d;
   logic [49:0]     lerp_prod;
   logic [34:0]     lerp_p_ext;
   logic [34:0]     lerp_addend;
   logic [34:0]     lerp_sum;
   logic [31:0]     lerp_res;

   logic [31:0]     lerp_a_ff;
   logic            lerp_neg_ff;
   logic [32:0]     lerp_mag_ff;
   logic [FRAC_W:0] lerp_f_ff;
   logic [33:0]     lerp_p_ff;
   logic [31:0]     left_ff;
   logic [31:0]     right_ff;
   logic [31:0]     res_ff;
   logic [31:0]     out_ff;

   always_comb begin
      unique case (cmd.lerp_sel)
         LERP_LEFT: begin
            lerp_a = cell_ff[0];
            lerp_b = cell_ff[1];
            lerp_f = frac_ff[1];
         end
         LERP_RIGHT: begin
            lerp_a = cell_ff[2];
            lerp_b = cell_ff[3];
            lerp_f = frac_ff[1];
         end
         default: begin
            lerp_a = left_ff;
            lerp_b = right_ff;
            lerp_f = frac_ff[0];
         end
      endcase
   end

   assign lerp_d      = {lerp_b[31], lerp_b} - {lerp_a[31], lerp_a};
   assign lerp_prod   = 50'(lerp_mag_ff) * 50'(lerp_f_ff);
   assign lerp_p_ext  = 35'(lerp_p_ff);
   assign lerp_addend = lerp_neg_ff ? (~lerp_p_ext + 35'd1) : lerp_p_ext;
   assign lerp_sum    = {{3{lerp_a_ff[31]}}, lerp_a_ff} + lerp_addend;
   assign lerp_res    = sat35(lerp_sum);

   // Difference, then truncated product magnitude, then saturating add
   always_ff @(posedge clock) begin
      unique case (cmd.lerp_step)
         LSTEP_IDLE: begin
         end
         LSTEP_DIFF: begin
            lerp_a_ff   <= lerp_a;
            lerp_neg_ff <= lerp_d[32];
            lerp_mag_ff <= lerp_d[32] ? (~lerp_d + 33'd1) : lerp_d;
            lerp_f_ff   <= lerp_f;
         end
         LSTEP_MUL: begin
            lerp_p_ff <= lerp_prod[49:FRAC_W];
         end
         LSTEP_ADD: begin
            unique case (cmd.lerp_sel)
               LERP_LEFT:  left_ff  <= lerp_res;
               LERP_RIGHT: right_ff <= lerp_res;
               default:    res_ff   <= lerp_res;
            endcase
         end
      endcase
      if (cmd.res_clr) begin
         res_ff <= '0;
      end
      if (cmd.out_load) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_z_adj = out_ff;

endmodule

`default_nettype wire

>>> design/mbz_ctrl.sv
`default_nettype none

module mbz_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_func,
   input  logic             mesh_valid,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mbz_pkg::cmd_type cmd,
   input  mbz_pkg::sts_type sts
);
   import mbz_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_LOC,
      ST_READ,
      ST_DIFF,
      ST_MUL,
      ST_ADD,
      ST_OUT
   } state_type;

   state_type    state_ff;
   logic [2:0]   rd_cnt_ff;
   lerp_sel_type lsel_ff;
   logic         rsp_valid_ff;
   logic         accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Decode commands from the current state
   always_comb begin
      cmd           = '0;
      cmd.rd_sel    = rd_cnt_ff[1:0];
      cmd.cap_sel   = 2'(rd_cnt_ff - 3'd1);
      cmd.lerp_sel  = lsel_ff;
      cmd.lerp_step = LSTEP_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_func == FUNC_LOAD) begin
                  cmd.mem_wr = 1'b1;
               end else if (!mesh_valid) begin
                  cmd.res_clr = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
               end
            end
         end
         ST_PREP: cmd.div_start = 1'b1;
         ST_DIV:  begin
         end
         ST_LOC:  cmd.locate = 1'b1;
         ST_READ: begin
            cmd.rd_en  = !rd_cnt_ff[2];
            cmd.cap_en = (rd_cnt_ff != 3'd0);
         end
         ST_DIFF: cmd.lerp_step = LSTEP_DIFF;
         ST_MUL:  cmd.lerp_step = LSTEP_MUL;
         ST_ADD:  cmd.lerp_step = LSTEP_ADD;
         ST_OUT:  cmd.out_load = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   // Sequence one request; hold the result until the response side takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         lsel_ff      <= LERP_LEFT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_func == FUNC_QUERY) begin
                  state_ff <= mesh_valid ? ST_PREP : ST_OUT;
               end
            end
            ST_PREP: state_ff <= ST_DIV;
            ST_DIV: begin
               if (sts.div_done) begin
                  state_ff <= ST_LOC;
               end
            end
            ST_LOC: begin
               rd_cnt_ff <= '0;
               state_ff  <= ST_READ;
            end
            ST_READ: begin
               rd_cnt_ff <= rd_cnt_ff + 3'd1;
               if (rd_cnt_ff == 3'd4) begin
                  lsel_ff  <= LERP_LEFT;
                  state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: state_ff <= ST_MUL;
            ST_MUL:  state_ff <= ST_ADD;
            ST_ADD: begin
               if (lsel_ff == LERP_FINAL) begin
                  state_ff <= ST_OUT;
               end else begin
                  lsel_ff  <= (lsel_ff == LERP_LEFT) ? LERP_RIGHT : LERP_FINAL;
                  state_ff <= ST_DIFF;
               end
            end
            ST_OUT: begin
               if (cmd.out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> design/mesh_bilinear_z_offset.sv
// Query: one query at a time; req_ready is low from acceptance until the result is loaded for
// the response side, which can stall it. The two spacing dividers produce one quotient bit per
// cycle over log2(MAX_POINTS) + 16 bits.
// Query with the mesh marked invalid: the response is zero. Load: written when accepted.
// Reset (synchronous, active high) clears control state and restores register defaults;
// grid entries are undefined until loaded.
`default_nettype none

module mesh_bilinear_z_offset #(
   parameter int MAX_POINTS = mbz_pkg::MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Configuration write port
   input  logic                          csr_we,
   input  logic [mbz_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [3:0]                    req_grid_col,
   input  logic [3:0]                    req_grid_row,
   input  logic signed [31:0]            req_entry_value,
   input  logic signed [31:0]            req_query_x,
   input  logic signed [31:0]            req_query_y,
   // Response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_z_adj
);
   import mbz_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x   <= ORIGIN_X_RST;
         cfg_ff.origin_y   <= ORIGIN_Y_RST;
         cfg_ff.spacing_x  <= SPACING_X_RST;
         cfg_ff.spacing_y  <= SPACING_Y_RST;
         cfg_ff.points_x   <= POINTS_X_RST;
         cfg_ff.points_y   <= POINTS_Y_RST;
         cfg_ff.mesh_valid <= MESH_VALID_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X:   cfg_ff.origin_x   <= csr_wdata;
            CSR_ORIGIN_Y:   cfg_ff.origin_y   <= csr_wdata;
            CSR_SPACING_X:  cfg_ff.spacing_x  <= csr_wdata[30:0];
            CSR_SPACING_Y:  cfg_ff.spacing_y  <= csr_wdata[30:0];
            CSR_POINTS_X:   cfg_ff.points_x   <= csr_wdata[4:0];
            CSR_POINTS_Y:   cfg_ff.points_y   <= csr_wdata[4:0];
            CSR_MESH_VALID: cfg_ff.mesh_valid <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   mbz_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .mesh_valid (cfg_ff.mesh_valid),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   mbz_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .sts             (sts),
      .req_grid_col    (req_grid_col),
      .req_grid_row    (req_grid_row),
      .req_entry_value (req_entry_value),
      .req_query_x     (req_query_x),
      .req_query_y     (req_query_y),
      .rsp_z_adj       (rsp_z_adj)
   );

   // An invalid mesh answers zero to a query taken while no response is waiting
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == FUNC_QUERY && !cfg_ff.mesh_valid && !rsp_valid)
      |=> ##1 (rsp_valid && rsp_z_adj == '0))
      else $error("invalid mesh query did not return zero");

   // Never overwrite a response that is still waiting
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("response overwritten before it was taken");

   // Grid writes only come from accepted load requests
   a_wr_src: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_wr |-> (req_valid && req_ready && req_func == FUNC_LOAD))
      else $error("grid write without a load request");

   // A divider start drops the done status
   a_div_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !sts.div_done)
      else $error("divider done did not clear on start");

endmodule

`default_nettype wire
